// ===== hw/rtl/pva_pkg.sv =====
// pva_pkg: shared codes and widths for the polyphonic voice allocator
// no dependencies; imported by pva_scan and polyphonic_voice_allocator

package pva_pkg;

   localparam int NOTE_W  = 7;
   localparam int STAMP_W = 32;
   localparam int POLY_W  = 5;

   localparam logic [POLY_W-1:0] POLYPHONY_RESET = 5'd16;

   // input command codes
   typedef enum logic [1:0] {
      CMD_NOTE_ON  = 2'd0,
      CMD_NOTE_OFF = 2'd1,
      CMD_FINISHED = 2'd2,
      CMD_ALL_OFF  = 2'd3
   } pva_cmd_type;

   // result action codes
   typedef enum logic [1:0] {
      ACT_NONE        = 2'd0,
      ACT_TRIGGER     = 2'd1,
      ACT_RELEASE     = 2'd2,
      ACT_RELEASE_ALL = 2'd3
   } pva_action_type;

   // how a note-on slot was picked
   typedef enum logic [1:0] {
      HOW_RETRIGGER = 2'd0,
      HOW_FREE      = 2'd1,
      HOW_STOLEN    = 2'd2
   } pva_how_type;

   // control from the sequencer to the slot compare unit
   typedef struct packed {
      logic start;   // clear trackers before a pass
      logic valid;   // read data of one slot is present
      logic active;  // that slot's active mark
   } pva_scan_ctl_type;

   // flags back from the compare unit
   typedef struct packed {
      logic match_found;
      logic free_found;
   } pva_scan_res_type;

endpackage

// ===== hw/rtl/pva_ram.sv =====
// pva_ram: generic single-write, single-read ram with registered read
// no dependencies; holds slot note and stamp for the voice allocator

module pva_ram #(
   parameter int WIDTH = 39,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/pva_scan.sv =====
// pva_scan: shared compare unit that walks slots one per cycle
// depends on pva_pkg; finds same-note match, lowest free slot, oldest stamp, count

module pva_scan #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  pva_pkg::pva_scan_ctl_type                   ctl,
   input  logic [IDX_W-1:0]                            slot_idx,
   input  logic [pva_pkg::NOTE_W-1:0]                  req_note,
   input  logic [pva_pkg::NOTE_W+pva_pkg::STAMP_W-1:0] slot_data,
   output pva_pkg::pva_scan_res_type                   res,
   output logic [IDX_W-1:0]                            match_idx,
   output logic [IDX_W-1:0]                            free_idx,
   output logic [IDX_W-1:0]                            oldest_idx,
   output logic [CNT_W-1:0]                            active_cnt
);
   import pva_pkg::*;

   logic                 match_found_ff, match_found_in;
   logic                 free_found_ff, free_found_in;
   logic                 first_ff, first_in;
   logic [IDX_W-1:0]     match_idx_ff, match_idx_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]     oldest_idx_ff, oldest_idx_in;
   logic [STAMP_W-1:0]   oldest_stamp_ff, oldest_stamp_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NOTE_W-1:0]    slot_note;
   logic [STAMP_W-1:0]   slot_stamp;

   assign slot_note  = slot_data[NOTE_W-1:0];
   assign slot_stamp = slot_data[NOTE_W+STAMP_W-1:NOTE_W];

   always_comb begin
      match_found_in  = match_found_ff;
      free_found_in   = free_found_ff;
      first_in        = first_ff;
      match_idx_in    = match_idx_ff;
      free_idx_in     = free_idx_ff;
      oldest_idx_in   = oldest_idx_ff;
      oldest_stamp_in = oldest_stamp_ff;
      cnt_in          = cnt_ff;
      if (ctl.start) begin
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
         first_in       = 1'b1;
         cnt_in         = '0;
      end else if (ctl.valid) begin
         first_in = 1'b0;
         if (ctl.active && (slot_note == req_note) && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = slot_idx;
         end
         if (!ctl.active && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = slot_idx;
         end
         // strict less-than keeps the lowest index on ties
         if (first_ff || (slot_stamp < oldest_stamp_ff)) begin
            oldest_idx_in   = slot_idx;
            oldest_stamp_in = slot_stamp;
         end
         if (ctl.active) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         first_ff       <= 1'b1;
         cnt_ff         <= '0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         first_ff       <= first_in;
         cnt_ff         <= cnt_in;
      end
      match_idx_ff    <= match_idx_in;
      free_idx_ff     <= free_idx_in;
      oldest_idx_ff   <= oldest_idx_in;
      oldest_stamp_ff <= oldest_stamp_in;
   end

   assign res.match_found = match_found_ff;
   assign res.free_found  = free_found_ff;
   assign match_idx       = match_idx_ff;
   assign free_idx        = free_idx_ff;
   assign oldest_idx      = oldest_idx_ff;
   assign active_cnt      = cnt_ff;

endmodule

// ===== hw/rtl/polyphonic_voice_allocator.sv =====
// polyphonic_voice_allocator: top level, sequencer, active marks and result register
// depends on pva_pkg, pva_ram and pva_scan
//
// channel | dir | handshake             | payload
// --------+-----+-----------------------+------------------------------------------
// req     | in  | req_tvalid/req_tready | tuser command, tdata note..finished_voice
// rsp     | out | rsp_tvalid/rsp_tready | tuser action, tdata voice_index..count
// csr     | in  | csr_valid/csr_ready   | csr_data polyphony
//
// an item is accepted in idle; the used slots (1..MAX_VOICES) are then read in turn
// through the single ram read port and the shared compare unit, a drain state
// empties the read pipe, and the done state commits.
// reset is synchronous: all slots inactive, trigger counter zero, polyphony 16.
// a waiting result does not block the next accept; only the commit waits for it.

module polyphonic_voice_allocator #(
   parameter int MAX_VOICES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] command
   input  logic [63:0] req_tdata,   // note[6:0], velocity[22:7], attack_ms[38:23],
                                    // decay_ms[54:39], finished_voice[58:55], zero above
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] action
   output logic [71:0] rsp_tdata,   // voice_index[3:0], how_chosen[5:4], out_note[12:6],
                                    // out_velocity[28:13], out_attack_ms[44:29],
                                    // out_decay_ms[60:45], active_count[65:61], zero above
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // polyphony
);
   import pva_pkg::*;

   localparam int IDX_W = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CNT_W = $clog2(MAX_VOICES + 1);
   localparam int RAM_W = NOTE_W + STAMP_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [POLY_W-1:0]    polyphony_ff;
   logic [CNT_W-1:0]     used_n;
   logic [MAX_VOICES-1:0] active_ff, active_in;
   logic [STAMP_W-1:0]   counter_ff, counter_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]     cmp_idx_ff;
   logic                 rd_last;

   // latched request
   pva_cmd_type          cmd_ff;
   logic [NOTE_W-1:0]    note_ff;
   logic [15:0]          vel_ff, att_ff, dec_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_tuser_ff, rsp_tuser_in;
   logic [71:0]          rsp_tdata_ff, rsp_tdata_in;

   logic                 req_fire, commit;
   logic [3:0]           fin_voice;
   logic [RAM_W-1:0]     ram_rdata;
   logic                 ram_we;
   logic [IDX_W-1:0]     pick_idx;
   pva_how_type          pick_how;
   pva_action_type       act;
   logic [IDX_W-1:0]     out_idx;
   logic [CNT_W-1:0]     out_cnt;

   pva_scan_ctl_type     scan_ctl;
   pva_scan_res_type     scan_res;
   logic [IDX_W-1:0]     match_idx, free_idx, oldest_idx;
   logic [CNT_W-1:0]     scan_cnt;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign fin_voice  = req_tdata[58:55];
   assign commit     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // zero acts as one slot, values past the slot count are clamped
   always_comb begin
      if (polyphony_ff == '0) begin
         used_n = CNT_W'(1);
      end else if (8'(polyphony_ff) > 8'(MAX_VOICES)) begin
         used_n = CNT_W'(MAX_VOICES);
      end else begin
         used_n = CNT_W'(polyphony_ff);
      end
   end

   assign rd_last = (CNT_W'(rd_idx_ff) == (used_n - CNT_W'(1)));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in  = ST_SCAN;
               rd_idx_in = '0;
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            if (rd_last) begin
               state_in = ST_DRAIN;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign scan_ctl.start  = req_fire;
   assign scan_ctl.valid  = cmp_valid_ff;
   assign scan_ctl.active = active_ff[cmp_idx_ff];

   pva_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_VOICES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (pick_idx),
      .wr_data ({counter_ff + STAMP_W'(1), note_ff}),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   pva_scan #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .slot_idx   (cmp_idx_ff),
      .req_note   (note_ff),
      .slot_data  (ram_rdata),
      .res        (scan_res),
      .match_idx  (match_idx),
      .free_idx   (free_idx),
      .oldest_idx (oldest_idx),
      .active_cnt (scan_cnt)
   );

   // note-on slot choice: retrigger, then lowest free, then oldest
   always_comb begin
      if (scan_res.match_found) begin
         pick_idx = match_idx;
         pick_how = HOW_RETRIGGER;
      end else if (scan_res.free_found) begin
         pick_idx = free_idx;
         pick_how = HOW_FREE;
      end else begin
         pick_idx = oldest_idx;
         pick_how = HOW_STOLEN;
      end
   end

   assign ram_we = commit && (cmd_ff == CMD_NOTE_ON);

   // result assembly and state updates at commit; finished marks clear at accept
   always_comb begin
      act          = ACT_NONE;
      out_idx      = '0;
      out_cnt      = scan_cnt;
      active_in    = active_ff;
      counter_in   = counter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_tuser_in = rsp_tuser_ff;
      rsp_tdata_in = rsp_tdata_ff;

      // voice finished clears its mark before the scan counts
      if (req_fire && (pva_cmd_type'(req_tuser) == CMD_FINISHED)) begin
         for (int i = 0; i < MAX_VOICES; i++) begin
            if (8'(fin_voice) == 8'(i)) begin
               active_in[i] = 1'b0;
            end
         end
      end

      case (cmd_ff)
         CMD_NOTE_ON: begin
            act     = ACT_TRIGGER;
            out_idx = pick_idx;
            if (pick_how == HOW_FREE) begin
               out_cnt = scan_cnt + CNT_W'(1);
            end
         end
         CMD_NOTE_OFF: begin
            if (scan_res.match_found) begin
               act     = ACT_RELEASE;
               out_idx = match_idx;
            end
         end
         CMD_ALL_OFF: begin
            act = ACT_RELEASE_ALL;
         end
         default: begin
            act = ACT_NONE;
         end
      endcase

      if (commit) begin
         if (cmd_ff == CMD_NOTE_ON) begin
            counter_in = counter_ff + STAMP_W'(1);
            for (int i = 0; i < MAX_VOICES; i++) begin
               if (pick_idx == IDX_W'(i)) begin
                  active_in[i] = 1'b1;
               end
            end
         end
         rsp_valid_in = 1'b1;
         rsp_tuser_in = act;
         rsp_tdata_in = '0;
         rsp_tdata_in[3:0]   = 4'(out_idx);
         rsp_tdata_in[65:61] = 5'(out_cnt);
         if (act == ACT_TRIGGER) begin
            rsp_tdata_in[5:4]   = pick_how;
            rsp_tdata_in[12:6]  = note_ff;
            rsp_tdata_in[28:13] = vel_ff;
            rsp_tdata_in[44:29] = att_ff;
            rsp_tdata_in[60:45] = dec_ff;
         end else if (act == ACT_RELEASE) begin
            // matched slot holds the same note
            rsp_tdata_in[12:6] = note_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         polyphony_ff <= POLYPHONY_RESET;
         active_ff    <= '0;
         counter_ff   <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         counter_ff   <= counter_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            polyphony_ff <= csr_data;
         end
      end
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= rd_idx_ff;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
      if (req_fire) begin
         cmd_ff  <= pva_cmd_type'(req_tuser);
         note_ff <= req_tdata[6:0];
         vel_ff  <= req_tdata[22:7];
         att_ff  <= req_tdata[38:23];
         dec_ff  <= req_tdata[54:39];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule
